### rtl/mdfl_pkg.sv
// shared types, codes and helpers for the motor drive fault latch
`default_nettype none

package mdfl_pkg;

    // default sample count before motor overtemperature latches
    localparam int OVERTEMP_SAMPLES_DEF = 2;

    // request kinds
    localparam logic [1:0] REQ_FAST   = 2'd0;
    localparam logic [1:0] REQ_SLOW   = 2'd1;
    localparam logic [1:0] REQ_OFFSET = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // observer states
    localparam logic [1:0] OBS_OTHER      = 2'd0;
    localparam logic [1:0] OBS_OPEN_LOOP  = 2'd1;
    localparam logic [1:0] OBS_ALIGN      = 2'd2;
    localparam logic [1:0] OBS_TO_OPEN    = 2'd3;

    // drive flag bit positions
    localparam int FL_RUN         = 0;
    localparam int FL_BRK_BLOCKED = 1;
    localparam int FL_HW_BREAK2   = 2;
    localparam int FL_HW_BREAK    = 3;
    localparam int FL_SAFE_DRIVE  = 4;
    localparam int FL_MAY_CLR2    = 5;
    localparam int FL_MAY_CLR     = 6;

    // fault mask bit positions
    localparam int FB_OVERVOLT  = 0;
    localparam int FB_UNDERVOLT = 1;
    localparam int FB_OVERCUR   = 2;
    localparam int FB_MOTORERR  = 3;
    localparam int FB_CTRLERR   = 4;
    localparam int FB_BRIDGE    = 5;
    localparam int FB_MOTORTEMP = 6;
    localparam int FB_OFFSET    = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PC_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS      = 3'd7;

    // configuration reset values
    localparam logic signed [15:0] OV_LIMIT_RST  = 16'sh7FFF;
    localparam logic signed [15:0] UV_LIMIT_RST  = 16'sh8000;
    localparam logic [14:0]        PC_LIMIT_RST  = 15'h7FFF;
    localparam logic signed [15:0] BT_LIMIT_RST  = 16'sh7FFF;
    localparam logic signed [15:0] MT_LIMIT_RST  = 16'sh7FFF;
    localparam logic [14:0]        OC_LIMIT_RST  = 15'h7FFF;
    localparam logic [15:0]        MOD_LIMIT_RST = 16'd39322;      // 0.6 in Q0.16
    localparam logic [31:0]        HOLD_MS_RST   = 32'd180000;     // three minutes

    typedef struct packed {
        logic signed [15:0] ov_limit;
        logic signed [15:0] uv_limit;
        logic [14:0]        pc_limit;
        logic signed [15:0] bt_limit;
        logic signed [15:0] mt_limit;
        logic [14:0]        oc_limit;
        logic [15:0]        mod_limit;
        logic [31:0]        hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] dc_link_voltage;
        logic signed [15:0] phase_current_a;
        logic signed [15:0] phase_current_b;
        logic signed [15:0] phase_current_c;
        logic signed [15:0] bridge_temp;
        logic signed [15:0] motor_temp;
        logic [31:0]        now_ms;
        logic [1:0]         observer_state;
        logic [6:0]         drive_flags;
        logic [15:0]        modulation_factor;
        logic               direction_kept;
    } t_req;

    typedef struct packed {
        logic [7:0] fault_mask;
        logic       break_pulse;
        logic       clear_break2;
        logic       clear_break;
    } t_res;

    // absolute value of a signed 16-bit quantity, saturated at 32767
    function automatic logic [14:0] abs_sat(input logic signed [15:0] v);
        logic [15:0] mag;
        mag = v[15] ? 16'(-v) : 16'(v);
        return mag[15] ? 15'h7FFF : mag[14:0];
    endfunction

endpackage

`default_nettype wire

### rtl/mdfl_if.sv
// channel interfaces: request, result and configuration write
`default_nettype none

interface mdfl_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] dc_link_voltage;
    logic signed [15:0] phase_current_a;
    logic signed [15:0] phase_current_b;
    logic signed [15:0] phase_current_c;
    logic signed [15:0] bridge_temp;
    logic signed [15:0] motor_temp;
    logic [31:0]        now_ms;
    logic [1:0]         observer_state;
    logic [6:0]         drive_flags;
    logic [15:0]        modulation_factor;
    logic               direction_kept;

    modport source (
        output valid, req_type, dc_link_voltage, phase_current_a, phase_current_b,
               phase_current_c, bridge_temp, motor_temp, now_ms, observer_state,
               drive_flags, modulation_factor, direction_kept,
        input  ready
    );
    modport sink (
        input  valid, req_type, dc_link_voltage, phase_current_a, phase_current_b,
               phase_current_c, bridge_temp, motor_temp, now_ms, observer_state,
               drive_flags, modulation_factor, direction_kept,
        output ready
    );
endinterface

interface mdfl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] fault_mask;
    logic       break_pulse;
    logic       clear_break2;
    logic       clear_break;

    modport source (
        output valid, fault_mask, break_pulse, clear_break2, clear_break,
        input  ready
    );
    modport sink (
        input  valid, fault_mask, break_pulse, clear_break2, clear_break,
        output ready
    );
endinterface

interface mdfl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

### rtl/mdfl_cfg_regs.sv
// configuration register bank for the fault latch limits
`default_nettype none

module mdfl_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [mdfl_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [31:0]                    i_data,
    output mdfl_pkg::t_cfg                      o_cfg
);
    import mdfl_pkg::*;

    t_cfg r_cfg;

    // register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_limit  <= OV_LIMIT_RST;
            r_cfg.uv_limit  <= UV_LIMIT_RST;
            r_cfg.pc_limit  <= PC_LIMIT_RST;
            r_cfg.bt_limit  <= BT_LIMIT_RST;
            r_cfg.mt_limit  <= MT_LIMIT_RST;
            r_cfg.oc_limit  <= OC_LIMIT_RST;
            r_cfg.mod_limit <= MOD_LIMIT_RST;
            r_cfg.hold_ms   <= HOLD_MS_RST;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_OV_LIMIT:  r_cfg.ov_limit  <= i_data[15:0];
                CFG_UV_LIMIT:  r_cfg.uv_limit  <= i_data[15:0];
                CFG_PC_LIMIT:  r_cfg.pc_limit  <= i_data[14:0];
                CFG_BT_LIMIT:  r_cfg.bt_limit  <= i_data[15:0];
                CFG_MT_LIMIT:  r_cfg.mt_limit  <= i_data[15:0];
                CFG_OC_LIMIT:  r_cfg.oc_limit  <= i_data[14:0];
                CFG_MOD_LIMIT: r_cfg.mod_limit <= i_data[15:0];
                CFG_HOLD_MS:   r_cfg.hold_ms   <= i_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/mdfl_eval.sv
// fault evaluation: sticky fault bits, overtemp counter and stamp
`default_nettype none

module mdfl_eval #(
    parameter int OVERTEMP_SAMPLES = mdfl_pkg::OVERTEMP_SAMPLES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire mdfl_pkg::t_req i_req,
    input  wire mdfl_pkg::t_cfg i_cfg,
    output mdfl_pkg::t_res      o_res
);
    import mdfl_pkg::*;

    localparam int CntW = (OVERTEMP_SAMPLES < 2) ? 1 : $clog2(OVERTEMP_SAMPLES + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(OVERTEMP_SAMPLES);

    logic [7:0]      r_fault, n_fault;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [31:0]     r_stamp, n_stamp;

    logic signed [15:0] dc, bt, mt;
    logic [14:0]        ia, ib, ic;
    logic [6:0]         fl;
    logic [1:0]         obs;
    logic [31:0]        elapsed;
    logic               pulse, clr2, clr1;

    assign dc  = $signed(i_req.dc_link_voltage);
    assign bt  = $signed(i_req.bridge_temp);
    assign mt  = $signed(i_req.motor_temp);
    assign ia  = abs_sat(i_req.phase_current_a);
    assign ib  = abs_sat(i_req.phase_current_b);
    assign ic  = abs_sat(i_req.phase_current_c);
    assign fl  = i_req.drive_flags;
    assign obs = i_req.observer_state;

    // time since stamp, wraps modulo 2^32
    assign elapsed = i_req.now_ms - r_stamp;

    // next state and side outputs for the current request
    always_comb begin
        n_fault = r_fault;
        n_cnt   = r_cnt;
        n_stamp = r_stamp;
        pulse   = 1'b0;
        clr2    = 1'b0;
        clr1    = 1'b0;
        unique case (i_req.req_type)
            REQ_FAST: begin
                if (dc > $signed(i_cfg.ov_limit)) begin
                    n_fault[FB_OVERVOLT] = 1'b1;
                    pulse                = 1'b1;
                end
                if (dc < $signed(i_cfg.uv_limit)) n_fault[FB_UNDERVOLT] = 1'b1;
                if (fl[FL_RUN]) begin
                    if (!fl[FL_BRK_BLOCKED]) begin
                        if (ia > i_cfg.pc_limit || ib > i_cfg.pc_limit ||
                            ic > i_cfg.pc_limit || fl[FL_HW_BREAK2]) begin
                            n_fault[FB_OVERCUR] = 1'b1;
                        end
                    end
                    if (fl[FL_HW_BREAK] && fl[FL_SAFE_DRIVE]) n_fault[FB_OVERVOLT] = 1'b1;
                end
                if (i_req.modulation_factor > i_cfg.mod_limit &&
                    (obs == OBS_OPEN_LOOP || obs == OBS_ALIGN)) begin
                    n_fault[FB_MOTORERR] = 1'b1;
                end
                if (i_req.direction_kept && obs == OBS_TO_OPEN) n_fault[FB_CTRLERR] = 1'b1;
            end
            REQ_SLOW: begin
                if (bt > $signed(i_cfg.bt_limit)) n_fault[FB_BRIDGE] = 1'b1;
                if (obs == OBS_OPEN_LOOP && mt > $signed(i_cfg.mt_limit)) begin
                    if (r_cnt >= CntMax) begin
                        // a stamp of zero reads as not stamped
                        if (r_stamp == 32'd0) n_stamp = i_req.now_ms;
                        n_fault[FB_MOTORTEMP] = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CntW'(1);
                    end
                end else begin
                    n_cnt = '0;
                end
            end
            REQ_OFFSET: begin
                if (ia > i_cfg.oc_limit || ib > i_cfg.oc_limit || ic > i_cfg.oc_limit) begin
                    n_fault[FB_OFFSET] = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_fault[FB_CTRLERR]  = 1'b0;
                n_fault[FB_MOTORERR] = 1'b0;
                if (ia < i_cfg.pc_limit && ib < i_cfg.pc_limit && ic < i_cfg.pc_limit) begin
                    clr2                = r_fault[FB_OVERCUR] & fl[FL_MAY_CLR2];
                    n_fault[FB_OVERCUR] = 1'b0;
                end
                if (dc < $signed(i_cfg.ov_limit)) begin
                    clr1                 = r_fault[FB_OVERVOLT] & fl[FL_MAY_CLR];
                    n_fault[FB_OVERVOLT] = 1'b0;
                end
                if (dc > $signed(i_cfg.uv_limit)) n_fault[FB_UNDERVOLT] = 1'b0;
                if (bt < $signed(i_cfg.bt_limit)) n_fault[FB_BRIDGE] = 1'b0;
                if (r_fault[FB_MOTORTEMP] && elapsed > i_cfg.hold_ms) begin
                    n_fault[FB_MOTORTEMP] = 1'b0;
                    n_stamp               = 32'd0;
                end
            end
            default: n_fault = r_fault;
        endcase
    end

    // state update once per transfer into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
            r_cnt   <= '0;
            r_stamp <= '0;
        end else if (i_en) begin
            r_fault <= n_fault;
            r_cnt   <= n_cnt;
            r_stamp <= n_stamp;
        end
    end

    assign o_res.fault_mask   = n_fault;
    assign o_res.break_pulse  = pulse;
    assign o_res.clear_break2 = clr2;
    assign o_res.clear_break  = clr1;

endmodule

`default_nettype wire

### rtl/motor_drive_fault_latch.sv
// top level of the motor drive fault latch
//
//  channel  | dir | content
//  ---------+-----+------------------------------------------------
//  i_req    | in  | request kind, measurements, flags, tick time
//  o_res    | out | fault mask, break pulse, break flag clears
//  i_cfg    | in  | limit register writes (index, data)
//
// one request per clock sustained while results are taken; each result reaches o_res
// through the input register, then evaluation into the result register
// fault bits and the overtemp counter and stamp move as a result is registered
// a held result stalls the input register and then i_req.ready, never drops an item
// synchronous active low reset clears faults, counter, stamp and limits to defaults
// configuration writes are taken every cycle
`default_nettype none

module motor_drive_fault_latch #(
    parameter int OVERTEMP_SAMPLES = mdfl_pkg::OVERTEMP_SAMPLES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mdfl_req_if.sink   i_req,
    mdfl_res_if.source o_res,
    mdfl_cfg_if.sink   i_cfg
);
    import mdfl_pkg::*;

    t_cfg cfg;
    t_req r_s1;
    t_res r_out;
    t_res eval_res;
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_xfer;

    // configuration bank
    assign i_cfg.ready = 1'b1;

    mdfl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_index (i_cfg.wr_index),
        .i_data  (i_cfg.wr_data),
        .o_cfg   (cfg)
    );

    // handshake: input stage moves when the result register is free or being taken
    assign s1_adv      = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_xfer     = i_req.valid && i_req.ready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) r_s1_valid <= i_req.valid;
            if (s1_adv) r_out_valid <= r_s1_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.req_type          <= i_req.req_type;
            r_s1.dc_link_voltage   <= i_req.dc_link_voltage;
            r_s1.phase_current_a   <= i_req.phase_current_a;
            r_s1.phase_current_b   <= i_req.phase_current_b;
            r_s1.phase_current_c   <= i_req.phase_current_c;
            r_s1.bridge_temp       <= i_req.bridge_temp;
            r_s1.motor_temp        <= i_req.motor_temp;
            r_s1.now_ms            <= i_req.now_ms;
            r_s1.observer_state    <= i_req.observer_state;
            r_s1.drive_flags       <= i_req.drive_flags;
            r_s1.modulation_factor <= i_req.modulation_factor;
            r_s1.direction_kept    <= i_req.direction_kept;
        end
    end

    // evaluation against the sticky state
    mdfl_eval #(
        .OVERTEMP_SAMPLES (OVERTEMP_SAMPLES)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_s1_valid && s1_adv),
        .i_req   (r_s1),
        .i_cfg   (cfg),
        .o_res   (eval_res)
    );

    // result register payload
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) r_out <= eval_res;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.fault_mask   = r_out.fault_mask;
    assign o_res.break_pulse  = r_out.break_pulse;
    assign o_res.clear_break2 = r_out.clear_break2;
    assign o_res.clear_break  = r_out.clear_break;

`ifndef SYNTHESIS
    // a break pulse always comes with the overvoltage fault latched
    a_pulse_has_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.break_pulse |-> r_out.fault_mask[FB_OVERVOLT])
        else $error("break pulse without overvoltage fault");

    // a break flag release means its fault has just been cleared
    a_clr2_no_oc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clear_break2 |-> !r_out.fault_mask[FB_OVERCUR])
        else $error("break2 release with overcurrent still set");

    a_clr1_no_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clear_break |-> !r_out.fault_mask[FB_OVERVOLT])
        else $error("break release with overvoltage still set");

    // fast check and clear request outputs never mix
    a_pulse_vs_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.break_pulse && (r_out.clear_break || r_out.clear_break2)))
        else $error("break pulse together with break release");

    // an empty input register always takes a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_req.ready)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire
